@@ rtl/core/atrsb_pkg.sv @@
package atrsb_pkg;

    localparam int unsigned NUM_BUCKETS_DEF = 4;
    localparam int unsigned KINDS           = 4;
    localparam int unsigned NUM_EDGES       = 3;
    localparam int unsigned EDGE_W          = 40;
    localparam int unsigned SEQ_W           = 48;
    localparam int unsigned PRICE_W         = 24;
    localparam int unsigned VOL_W           = 30;
    localparam int unsigned PROD_W          = PRICE_W + VOL_W;
    localparam int unsigned RUNVOL_W        = 48;
    localparam int unsigned TOTAL_W         = 63;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam logic [EDGE_W-1:0] EDGE_LOW_RST  = 40'd4000000;
    localparam logic [EDGE_W-1:0] EDGE_MID_RST  = 40'd20000000;
    localparam logic [EDGE_W-1:0] EDGE_HIGH_RST = 40'd100000000;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_HIGH = 2'd2;

    localparam logic [1:0] FUNC_FILL  = 2'd0;
    localparam logic [1:0] FUNC_OTHER = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [1:0] KIND_BUY_AMT  = 2'd0;
    localparam logic [1:0] KIND_SELL_AMT = 2'd1;
    localparam logic [1:0] KIND_BUY_VOL  = 2'd2;
    localparam logic [1:0] KIND_SELL_VOL = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [SEQ_W-1:0]   bid_order_seq;
        logic [SEQ_W-1:0]   offer_order_seq;
        logic [PRICE_W-1:0] price_cents;
        logic [VOL_W-1:0]   fill_volume;
    } t_in;

    typedef struct packed {
        logic [1:0]         total_kind;
        logic [1:0]         bucket_index;
        logic [TOTAL_W-1:0] total_value;
        logic               last_total;
    } t_out;

    typedef struct packed {
        logic [1:0]        func;
        logic [SEQ_W-1:0]  bid_seq;
        logic [SEQ_W-1:0]  offer_seq;
        logic [VOL_W-1:0]  volume;
        logic [PROD_W-1:0] amount;
    } t_s2;

    function automatic logic [TOTAL_W-1:0] sat_add_total(
        input logic [TOTAL_W-1:0] a,
        input logic [TOTAL_W-1:0] b
    );
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [RUNVOL_W-1:0] sat_add_vol(
        input logic [RUNVOL_W-1:0] a,
        input logic [RUNVOL_W-1:0] b
    );
        logic [RUNVOL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RUNVOL_W] ? {RUNVOL_W{1'b1}} : s[RUNVOL_W-1:0];
    endfunction

endpackage

@@ rtl/core/atrsb_front.sv @@
module atrsb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  atrsb_pkg::t_in   i_in,
    input  logic             i_drain_free,
    output logic             o_fire,
    output atrsb_pkg::t_s2   o_s2
);

    logic             r_v1;
    atrsb_pkg::t_in   r_s1;
    logic             r_v2;
    atrsb_pkg::t_s2   r_s2;
    logic             s2_ready;
    logic             in_acc;

    // An end item may only leave the second stage when the output buffer can take a snapshot.
    assign s2_ready   = !(r_v2 && (r_s2.func == atrsb_pkg::FUNC_END)) || i_drain_free;
    assign o_in_ready = !r_v1 || s2_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_fire     = r_v2 && s2_ready;
    assign o_s2       = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (s2_ready) begin
                r_v1 <= 1'b0;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in;
        end
        if (s2_ready) begin
            r_s2.func      <= r_s1.func;
            r_s2.bid_seq   <= r_s1.bid_order_seq;
            r_s2.offer_seq <= r_s1.offer_order_seq;
            r_s2.volume    <= r_s1.fill_volume;
            r_s2.amount    <= atrsb_pkg::PROD_W'(r_s1.price_cents) *
                              atrsb_pkg::PROD_W'(r_s1.fill_volume);
        end
    end

endmodule

@@ rtl/core/atrsb_bucket_sel.sv @@
module atrsb_bucket_sel #(
    parameter int unsigned NUM_BUCKETS = atrsb_pkg::NUM_BUCKETS_DEF
) (
    input  logic [atrsb_pkg::TOTAL_W-1:0]                         i_amount,
    input  logic [atrsb_pkg::NUM_EDGES-1:0][atrsb_pkg::EDGE_W-1:0] i_edges,
    output logic [$clog2(NUM_BUCKETS)-1:0]                        o_bucket
);

    localparam int unsigned BW = $clog2(NUM_BUCKETS);

    logic [NUM_BUCKETS-2:0] hit;

    for (genvar d = 0; d < NUM_BUCKETS - 1; d++) begin : g_hit
        logic at_least;
        logic below_next;
        if (d == 0) begin : g_ge0
            assign at_least = 1'b1;
        end else if (d <= atrsb_pkg::NUM_EDGES) begin : g_ge
            assign at_least = i_amount >= atrsb_pkg::TOTAL_W'(i_edges[d-1]);
        end else begin : g_gen
            assign at_least = 1'b0;
        end
        if (d + 1 <= atrsb_pkg::NUM_EDGES) begin : g_lt
            assign below_next = i_amount < atrsb_pkg::TOTAL_W'(i_edges[d]);
        end else begin : g_ltn
            assign below_next = 1'b1;
        end
        assign hit[d] = at_least && below_next;
    end

    always_comb begin
        o_bucket = BW'(NUM_BUCKETS - 1);
        for (int d = NUM_BUCKETS - 2; d >= 0; d--) begin
            if (hit[d]) begin
                o_bucket = BW'(d);
            end
        end
    end

endmodule

@@ rtl/core/atrsb_accum.sv @@
module atrsb_accum #(
    parameter int unsigned NUM_BUCKETS = atrsb_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [atrsb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [atrsb_pkg::EDGE_W-1:0]           i_cfg_data,
    input  logic                                   i_fire,
    input  atrsb_pkg::t_s2                         i_s2,
    output logic                                   o_load,
    output logic [atrsb_pkg::KINDS-1:0][NUM_BUCKETS-1:0][atrsb_pkg::TOTAL_W-1:0] o_totals
);

    localparam int unsigned BW  = $clog2(NUM_BUCKETS);
    localparam int unsigned TW  = atrsb_pkg::TOTAL_W;
    localparam int unsigned RVW = atrsb_pkg::RUNVOL_W;

    logic [atrsb_pkg::NUM_EDGES-1:0][atrsb_pkg::EDGE_W-1:0] r_edge;
    logic [atrsb_pkg::SEQ_W-1:0] r_prev_bid, n_prev_bid;
    logic [atrsb_pkg::SEQ_W-1:0] r_prev_offer, n_prev_offer;
    logic [TW-1:0]               r_buy_amt, n_buy_amt;
    logic [TW-1:0]               r_sell_amt, n_sell_amt;
    logic [RVW-1:0]              r_buy_vol, n_buy_vol;
    logic [RVW-1:0]              r_sell_vol, n_sell_vol;
    logic [atrsb_pkg::KINDS-1:0][NUM_BUCKETS-1:0][TW-1:0] r_tot, n_tot;

    logic           is_fill;
    logic           is_end;
    logic           is_buy;
    logic           extend;
    logic           fl_sell;
    logic           fl_en;
    logic [TW-1:0]  fl_amt;
    logic [RVW-1:0] fl_vol;
    logic [BW-1:0]  fl_bucket;
    logic [TW-1:0]  run_amt_sum;
    logic [RVW-1:0] run_vol_sum;

    assign is_fill = i_fire && (i_s2.func == atrsb_pkg::FUNC_FILL);
    assign is_end  = i_fire && (i_s2.func == atrsb_pkg::FUNC_END);
    assign is_buy  = i_s2.bid_seq > i_s2.offer_seq;
    assign extend  = is_buy ? (r_prev_bid == i_s2.bid_seq) : (r_prev_offer == i_s2.offer_seq);
    assign fl_sell = (r_buy_amt == '0);
    assign fl_amt  = fl_sell ? r_sell_amt : r_buy_amt;
    assign fl_vol  = fl_sell ? r_sell_vol : r_buy_vol;
    assign fl_en   = is_fill && !extend && (fl_amt != '0);
    assign o_load  = is_end;
    assign o_totals = r_tot;

    assign run_amt_sum = atrsb_pkg::sat_add_total(is_buy ? r_buy_amt : r_sell_amt,
                                                  TW'(i_s2.amount));
    assign run_vol_sum = atrsb_pkg::sat_add_vol(is_buy ? r_buy_vol : r_sell_vol,
                                                RVW'(i_s2.volume));

    atrsb_bucket_sel #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_bucket_sel (
        .i_amount(fl_amt),
        .i_edges (r_edge),
        .o_bucket(fl_bucket)
    );

    // Each bucket column keeps its own adders, so every total is read at a fixed place.
    for (genvar b = 0; b < NUM_BUCKETS; b++) begin : g_col
        logic          hit;
        logic [TW-1:0] amt_sum;
        logic [TW-1:0] vol_sum;
        assign hit     = fl_en && (fl_bucket == BW'(b));
        assign amt_sum = atrsb_pkg::sat_add_total(
                             fl_sell ? r_tot[atrsb_pkg::KIND_SELL_AMT][b]
                                     : r_tot[atrsb_pkg::KIND_BUY_AMT][b],
                             fl_amt);
        assign vol_sum = atrsb_pkg::sat_add_total(
                             fl_sell ? r_tot[atrsb_pkg::KIND_SELL_VOL][b]
                                     : r_tot[atrsb_pkg::KIND_BUY_VOL][b],
                             TW'(fl_vol));
        always_comb begin
            n_tot[atrsb_pkg::KIND_BUY_AMT][b]  = r_tot[atrsb_pkg::KIND_BUY_AMT][b];
            n_tot[atrsb_pkg::KIND_SELL_AMT][b] = r_tot[atrsb_pkg::KIND_SELL_AMT][b];
            n_tot[atrsb_pkg::KIND_BUY_VOL][b]  = r_tot[atrsb_pkg::KIND_BUY_VOL][b];
            n_tot[atrsb_pkg::KIND_SELL_VOL][b] = r_tot[atrsb_pkg::KIND_SELL_VOL][b];
            if (is_end) begin
                n_tot[atrsb_pkg::KIND_BUY_AMT][b]  = '0;
                n_tot[atrsb_pkg::KIND_SELL_AMT][b] = '0;
                n_tot[atrsb_pkg::KIND_BUY_VOL][b]  = '0;
                n_tot[atrsb_pkg::KIND_SELL_VOL][b] = '0;
            end else if (hit && fl_sell) begin
                n_tot[atrsb_pkg::KIND_SELL_AMT][b] = amt_sum;
                n_tot[atrsb_pkg::KIND_SELL_VOL][b] = vol_sum;
            end else if (hit) begin
                n_tot[atrsb_pkg::KIND_BUY_AMT][b] = amt_sum;
                n_tot[atrsb_pkg::KIND_BUY_VOL][b] = vol_sum;
            end
        end
    end

    always_comb begin
        n_prev_bid   = r_prev_bid;
        n_prev_offer = r_prev_offer;
        n_buy_amt    = r_buy_amt;
        n_buy_vol    = r_buy_vol;
        n_sell_amt   = r_sell_amt;
        n_sell_vol   = r_sell_vol;
        if (is_end) begin
            n_prev_bid   = '0;
            n_prev_offer = '0;
            n_buy_amt    = '0;
            n_buy_vol    = '0;
            n_sell_amt   = '0;
            n_sell_vol   = '0;
        end else if (is_fill) begin
            n_prev_bid   = i_s2.bid_seq;
            n_prev_offer = i_s2.offer_seq;
            if (is_buy) begin
                n_buy_amt  = extend ? run_amt_sum : TW'(i_s2.amount);
                n_buy_vol  = extend ? run_vol_sum : RVW'(i_s2.volume);
                n_sell_amt = '0;
                n_sell_vol = '0;
            end else begin
                n_sell_amt = extend ? run_amt_sum : TW'(i_s2.amount);
                n_sell_vol = extend ? run_vol_sum : RVW'(i_s2.volume);
                n_buy_amt  = '0;
                n_buy_vol  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge[0]    <= atrsb_pkg::EDGE_LOW_RST;
            r_edge[1]    <= atrsb_pkg::EDGE_MID_RST;
            r_edge[2]    <= atrsb_pkg::EDGE_HIGH_RST;
            r_prev_bid   <= '0;
            r_prev_offer <= '0;
            r_buy_amt    <= '0;
            r_buy_vol    <= '0;
            r_sell_amt   <= '0;
            r_sell_vol   <= '0;
            r_tot        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    atrsb_pkg::CFG_EDGE_LOW:  r_edge[0] <= i_cfg_data;
                    atrsb_pkg::CFG_EDGE_MID:  r_edge[1] <= i_cfg_data;
                    atrsb_pkg::CFG_EDGE_HIGH: r_edge[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            r_prev_bid   <= n_prev_bid;
            r_prev_offer <= n_prev_offer;
            r_buy_amt    <= n_buy_amt;
            r_buy_vol    <= n_buy_vol;
            r_sell_amt   <= n_sell_amt;
            r_sell_vol   <= n_sell_vol;
            r_tot        <= n_tot;
        end
    end

endmodule

@@ rtl/core/atrsb_drain.sv @@
module atrsb_drain #(
    parameter int unsigned NUM_BUCKETS = atrsb_pkg::NUM_BUCKETS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [atrsb_pkg::KINDS-1:0][NUM_BUCKETS-1:0][atrsb_pkg::TOTAL_W-1:0] i_totals,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output atrsb_pkg::t_out       o_out
);

    localparam int unsigned BW = $clog2(NUM_BUCKETS);

    logic [atrsb_pkg::KINDS-1:0][NUM_BUCKETS-1:0][atrsb_pkg::TOTAL_W-1:0] r_buf;
    logic          r_busy;
    logic [1:0]    r_kind;
    logic [BW-1:0] r_bkt;
    logic          last_bkt;
    logic          last;
    logic          out_acc;

    assign last_bkt    = (r_bkt == BW'(NUM_BUCKETS - 1));
    assign last        = last_bkt && (r_kind == atrsb_pkg::KIND_SELL_VOL);
    assign out_acc     = r_busy && i_out_ready;
    assign o_free      = !r_busy || (out_acc && last);
    assign o_out_valid = r_busy;

    assign o_out.total_kind   = r_kind;
    assign o_out.bucket_index = 2'(r_bkt);
    assign o_out.total_value  = r_buf[r_kind][r_bkt];
    assign o_out.last_total   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= atrsb_pkg::KIND_BUY_AMT;
            r_bkt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_kind <= atrsb_pkg::KIND_BUY_AMT;
            r_bkt  <= '0;
        end else if (out_acc) begin
            if (last) begin
                r_busy <= 1'b0;
            end
            if (last_bkt) begin
                r_bkt  <= '0;
                r_kind <= r_kind + 2'd1;
            end else begin
                r_bkt <= r_bkt + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_totals;
        end
    end

endmodule

@@ rtl/core/active_trade_run_size_buckets_top.sv @@
// Sorts one symbol's fills into active buy and sell runs and adds each finished run's amount
// and volume into one of NUM_BUCKETS size buckets chosen by the low, mid and high edges. An item
// is taken every cycle unless an end item is held: a fill passes an input register, the
// price-by-volume multiply and then the run and bucket update. An end item copies the totals
// into an output buffer and clears run and total state in the same cycle; the 4*NUM_BUCKETS
// totals leave one per cycle while the output is ready, as fills keep flowing. A second end item
// waits in the pipeline until the previous burst has fully drained. Edge registers are written
// through a plain write port and are read by every fill; no clearing pass is needed after reset.
module active_trade_run_size_buckets_top #(
    parameter int unsigned NUM_BUCKETS = atrsb_pkg::NUM_BUCKETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  atrsb_pkg::t_in                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output atrsb_pkg::t_out                 o_out,
    input  logic                            i_cfg_we,
    input  logic [atrsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atrsb_pkg::EDGE_W-1:0]    i_cfg_data
);

    logic           drain_free;
    logic           fire;
    atrsb_pkg::t_s2 s2;
    logic           load;
    logic [atrsb_pkg::KINDS-1:0][NUM_BUCKETS-1:0][atrsb_pkg::TOTAL_W-1:0] totals;

    atrsb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_drain_free(drain_free),
        .o_fire      (fire),
        .o_s2        (s2)
    );

    atrsb_accum #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_s2       (s2),
        .o_load     (load),
        .o_totals   (totals)
    );

    atrsb_drain #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_totals   (totals),
        .o_free     (drain_free),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule
